@@ hdl/lpfs_pkg.sv @@
package lpfs_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 21;
    localparam int SHIFT_W    = 32;
    localparam int TDATA_W    = 32;
    localparam int TUSER_W    = 2;

    // header byte positions of the big-endian payload length
    localparam int LEN_FIRST  = 12;
    localparam int LEN_LAST   = 15;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 21'd65536;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              in_header;
        logic              frame_end;
        logic [LEN_W-1:0]  payload_length;
        logic              length_error;
    } t_result;

endpackage

@@ hdl/lpfs_parser.sv @@
module lpfs_parser
    import lpfs_pkg::*;
#(
    parameter int HEADER_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [LEN_W-1:0]  i_max_payload,
    output t_result           o_result
);

    localparam int CW = $clog2(HEADER_BYTES);
    localparam logic [CW-1:0] HDR_LAST = CW'(HEADER_BYTES - 1);
    localparam logic [CW-1:0] IDX_FIRST = CW'(LEN_FIRST);
    localparam logic [CW-1:0] IDX_LAST = CW'(LEN_LAST);

    logic [CW-1:0]      r_header_count, n_header_count;
    logic [SHIFT_W-1:0] r_length_shift, n_length_shift;
    logic [LEN_W-1:0]   r_payload_left, n_payload_left;
    logic               r_in_payload,   n_in_payload;
    logic               r_error,        n_error;

    logic frame_last;

    always_comb begin
        n_header_count = r_header_count;
        n_length_shift = r_length_shift;
        n_payload_left = r_payload_left;
        n_in_payload   = r_in_payload;
        n_error        = r_error;
        frame_last     = (r_payload_left <= LEN_W'(1));

        o_result.out_byte       = i_rx_byte;
        o_result.in_header      = 1'b0;
        o_result.frame_end      = 1'b0;
        o_result.payload_length = '0;
        o_result.length_error   = r_error;

        if (r_error) begin
            // sticky: everything after an oversize length is discarded
        end else if (r_in_payload) begin
            o_result.frame_end      = frame_last;
            o_result.payload_length = r_length_shift[LEN_W-1:0];
            if (frame_last) begin
                n_payload_left = '0;
                n_in_payload   = 1'b0;
                n_header_count = '0;
            end else begin
                n_payload_left = r_payload_left - LEN_W'(1);
            end
        end else begin
            if (r_header_count >= IDX_FIRST && r_header_count <= IDX_LAST) begin
                n_length_shift = {r_length_shift[SHIFT_W-BYTE_W-1:0], i_rx_byte};
            end
            if (r_header_count >= HDR_LAST) begin
                n_header_count = '0;
                if (n_length_shift > SHIFT_W'(i_max_payload)) begin
                    n_error               = 1'b1;
                    o_result.length_error = 1'b1;
                end else if (n_length_shift == '0) begin
                    o_result.in_header = 1'b1;
                    o_result.frame_end = 1'b1;
                end else begin
                    o_result.in_header      = 1'b1;
                    o_result.payload_length = n_length_shift[LEN_W-1:0];
                    n_payload_left          = n_length_shift[LEN_W-1:0];
                    n_in_payload            = 1'b1;
                end
            end else begin
                n_header_count     = r_header_count + CW'(1);
                o_result.in_header = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count <= '0;
            r_length_shift <= '0;
            r_payload_left <= '0;
            r_in_payload   <= 1'b0;
            r_error        <= 1'b0;
        end else if (i_accept) begin
            r_header_count <= n_header_count;
            r_length_shift <= n_length_shift;
            r_payload_left <= n_payload_left;
            r_in_payload   <= n_in_payload;
            r_error        <= n_error;
        end
    end

endmodule

@@ hdl/lpfs_out_reg.sv @@
module lpfs_out_reg
    import lpfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // a held result frees the register in the same cycle it is taken
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ hdl/length_prefixed_frame_splitter_core.sv @@
// Channel   Dir  Signals                          Content
// s_axis    in   tvalid tready tdata[7:0]         rx_byte
// m_axis    out  tvalid tready tdata tuser tlast  framed byte with tags
// cfg       in   valid ready data[20:0]           max_payload (always ready)
//
// One item per cycle unless m_axis stalls; each result appears in the cycle
// after its item is taken, limited only by the header counter / length compare.
// Reset (synchronous, active low) clears the frame state and sticky error and
// loads max_payload with 65536. Input is taken whenever the output register is
// empty or being drained, so an m_axis stall holds s_axis within one item.
module length_prefixed_frame_splitter_core
    import lpfs_pkg::*;
#(
    parameter int HEADER_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [28:8] payload_length, zero pad
    output logic [TUSER_W-1:0] m_axis_tuser,   // [0] in_header, [1] length_error
    output logic               m_axis_tlast,   // frame_end

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LEN_W-1:0]   i_cfg_data
);

    logic [LEN_W-1:0] r_max_payload;
    logic             accept;
    logic             can_load;
    t_result          parse_result;
    t_result          out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_data;
        end
    end

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    lpfs_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (s_axis_tdata),
        .i_max_payload (r_max_payload),
        .o_result      (parse_result)
    );

    lpfs_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s_axis_tvalid),
        .i_result   (parse_result),
        .i_ready    (m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {{(TDATA_W - LEN_W - BYTE_W){1'b0}},
                           out_result.payload_length, out_result.out_byte};
    assign m_axis_tuser = {out_result.length_error, out_result.in_header};
    assign m_axis_tlast = out_result.frame_end;

endmodule
